>>> sv/encoder_pi_speed_position_loop_unit_macros.svh
// Assertion macros for the encoder PI speed and position loop unit.
// Used by files that carry concurrent assertions; expects clk and rst in scope.
`ifndef ENCODER_PI_SPEED_POSITION_LOOP_UNIT_MACROS_SVH
`define ENCODER_PI_SPEED_POSITION_LOOP_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define EPSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EPSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/epsl_pkg.sv
// Shared types, widths, register indexes and microcode for the encoder PI loop.
// No dependencies; imported by epsl_mul and the top level.
package epsl_pkg;

  localparam int A_W    = 35;  // multiplier operand A, signed
  localparam int B_W    = 25;  // multiplier operand B, signed
  localparam int PROD_W = A_W + B_W;
  localparam int ERR_W  = 33;
  localparam int INT_W  = 18;  // integral and drive, Q1.16 signed
  localparam int SUM_W  = PROD_W - 16 + 1;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam logic signed [INT_W-1:0] Q_ONE     = INT_W'(65536);
  localparam logic signed [INT_W-1:0] Q_NEG_ONE = -INT_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN         = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_SPAN_GAIN    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_DEADBAND = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_SPEED      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_NEGATE    = 4'd7;

  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_SPEED  = 3'd1;
  localparam step_t STEP_ERR    = 3'd2;
  localparam step_t STEP_HEIGHT = 3'd3;
  localparam step_t STEP_INTEG  = 3'd4;
  localparam step_t STEP_DRIVE  = 3'd5;
  localparam step_t STEP_STEER  = 3'd6;
  localparam step_t STEP_OUT    = 3'd7;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_SPEED, MUL_HEIGHT, MUL_KI, MUL_KP, MUL_PWM
  } mul_sel_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_CAPTURE, OP_SPEED, OP_HEIGHT, OP_INTEG, OP_DRIVE, OP_STEER, OP_OUTPUT
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT
  } jump_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    op_t      op;
    jump_t    jmp;
  } ctrl_t;

  // control store: one word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      STEP_IDLE:   w = '{MUL_NONE,   OP_CAPTURE, JMP_WAIT_IN};
      STEP_SPEED:  w = '{MUL_SPEED,  OP_NONE,    JMP_NEXT};
      STEP_ERR:    w = '{MUL_HEIGHT, OP_SPEED,   JMP_NEXT};
      STEP_HEIGHT: w = '{MUL_KI,     OP_HEIGHT,  JMP_NEXT};
      STEP_INTEG:  w = '{MUL_KP,     OP_INTEG,   JMP_NEXT};
      STEP_DRIVE:  w = '{MUL_NONE,   OP_DRIVE,   JMP_NEXT};
      STEP_STEER:  w = '{MUL_PWM,    OP_STEER,   JMP_NEXT};
      // PWM product stays selected so it holds while the result waits
      STEP_OUT:    w = '{MUL_PWM,    OP_OUTPUT,  JMP_WAIT_OUT};
      default:     w = '{MUL_NONE,   OP_NONE,    JMP_NEXT};
    endcase
    return w;
  endfunction

  function automatic logic signed [INT_W-1:0] clamp_one(logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(Q_ONE)) return Q_ONE;
    if (v < SUM_W'(Q_NEG_ONE)) return Q_NEG_ONE;
    return INT_W'(v);
  endfunction

endpackage

>>> sv/epsl_mul.sv
// Shared signed multiplier with a registered product.
// Depends on epsl_pkg for operand and product widths.
module epsl_mul import epsl_pkg::*; (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> sv/encoder_pi_speed_position_loop_unit.sv
// Encoder PI speed loop with height seeking: one channel, Q16.16.
// The result and out_valid are registered by the output step, the last step of the program.
// The 8-step control program shares one 35x25 multiplier; a new input is taken only in the
// idle step, after the last item is done, and the last step waits while the output is stalled.
// Reset (rst, synchronous): registers return to defaults, loop state clears to zero.
module encoder_pi_speed_position_loop_unit import epsl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   encoder_delta,
  input  logic signed [31:0]   goal_height,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          pwm_compare,
  output logic                 drive_forward,
  output logic signed [31:0]   measured_speed,
  output logic signed [31:0]   current_height
);

  // configuration
  logic [23:0] kp_gain, ki_span_gain, speed_scale, height_deadband, seek_speed;
  logic [15:0] pwm_period;
  logic [31:0] height_scale;
  logic        count_negate;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain         <= 24'd509805;
      ki_span_gain    <= 24'd17910;
      pwm_period      <= 16'd799;
      speed_scale     <= 24'd1538;
      height_scale    <= 32'd100818;
      height_deadband <= 24'd655;
      seek_speed      <= 24'd32768;
      count_negate    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KP_GAIN:         kp_gain         <= cfg_data[23:0];
        REG_KI_SPAN_GAIN:    ki_span_gain    <= cfg_data[23:0];
        REG_PWM_PERIOD:      pwm_period      <= cfg_data[15:0];
        REG_SPEED_SCALE:     speed_scale     <= cfg_data[23:0];
        REG_HEIGHT_SCALE:    height_scale    <= cfg_data;
        REG_HEIGHT_DEADBAND: height_deadband <= cfg_data[23:0];
        REG_SEEK_SPEED:      seek_speed      <= cfg_data[23:0];
        REG_COUNT_NEGATE:    count_negate    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  step_t pc, pc_next;
  ctrl_t cw;
  logic  in_fire, out_hold;

  assign cw       = ucode(pc);
  assign in_stall = (pc != STEP_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;

  always_comb begin
    case (cw.jmp)
      JMP_NEXT:     pc_next = pc + 3'd1;
      JMP_WAIT_IN:  pc_next = in_fire ? pc + 3'd1 : pc;
      JMP_WAIT_OUT: pc_next = out_hold ? pc : STEP_IDLE;
      default:      pc_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) pc <= STEP_IDLE;
    else     pc <= pc_next;
  end

  // datapath registers
  logic signed [15:0]       delta_q;
  logic signed [31:0]       goal_q;
  logic signed [31:0]       speed_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [INT_W-1:0]  u_q;
  logic signed [31:0]       target_speed;
  logic signed [INT_W-1:0]  scaled_integral;
  logic [31:0]              height_accumulator;
  logic                     direction_latch;

  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [B_W-1:0]    delta_ext;
  logic [INT_W-2:0]         u_mag;

  assign delta_ext = B_W'(delta_q);
  assign u_mag     = u_q[INT_W-1] ? (INT_W-1)'(-u_q) : u_q[INT_W-2:0];

  always_comb begin
    case (cw.mul_sel)
      MUL_SPEED: begin
        mul_a = A_W'({1'b0, speed_scale});
        mul_b = delta_ext;
      end
      MUL_HEIGHT: begin
        // negate before the floor shift so rounding follows the sign
        mul_a = A_W'({1'b0, height_scale});
        mul_b = count_negate ? -delta_ext : delta_ext;
      end
      MUL_KI: begin
        mul_a = A_W'(err_q);
        mul_b = B_W'({1'b0, ki_span_gain});
      end
      MUL_KP: begin
        mul_a = A_W'(err_q);
        mul_b = B_W'({1'b0, kp_gain});
      end
      MUL_PWM: begin
        mul_a = A_W'({1'b0, u_mag});
        mul_b = B_W'({1'b0, pwm_period});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  epsl_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // product arithmetic
  logic signed [PROD_W-17:0] prod_sh;
  logic                      speed_fits;
  logic signed [31:0]        speed_sat;
  logic signed [SUM_W-1:0]   integ_sum, drive_sum;
  logic signed [ERR_W-1:0]   diff, diff_mag;

  assign prod_sh    = prod[PROD_W-1:16];
  assign speed_fits = (&prod[PROD_W-1:31]) || !(|prod[PROD_W-1:31]);
  assign speed_sat  = speed_fits ? prod[31:0]
                    : (prod[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign integ_sum  = SUM_W'(prod_sh) + SUM_W'(scaled_integral);
  assign drive_sum  = SUM_W'(prod_sh) + SUM_W'(scaled_integral);
  assign diff       = ERR_W'($signed(height_accumulator)) - ERR_W'(goal_q);
  assign diff_mag   = diff[ERR_W-1] ? -diff : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed       <= '0;
      scaled_integral    <= '0;
      height_accumulator <= '0;
      direction_latch    <= 1'b0;
    end else begin
      case (cw.op)
        OP_HEIGHT: height_accumulator <= height_accumulator + prod[47:16];
        OP_INTEG:  scaled_integral    <= clamp_one(integ_sum);
        OP_STEER: begin
          if (u_q > 0)      direction_latch <= 1'b1;
          else if (u_q < 0) direction_latch <= 1'b0;
          if ($unsigned(diff_mag) >= ERR_W'(height_deadband)) begin
            // moving up takes a negative speed
            target_speed <= (diff <= 0) ? -$signed({8'd0, seek_speed})
                                        :  $signed({8'd0, seek_speed});
          end else begin
            target_speed <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_CAPTURE: begin
        if (in_fire) begin
          delta_q <= encoder_delta;
          goal_q  <= goal_height;
        end
      end
      OP_SPEED: begin
        speed_q <= speed_sat;
        err_q   <= ERR_W'(target_speed) - ERR_W'(speed_sat);
      end
      OP_DRIVE:  u_q   <= clamp_one(drive_sum);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_OUTPUT && !out_hold) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_OUTPUT && !out_hold) begin
      pwm_compare    <= prod[31:16];
      drive_forward  <= direction_latch;
      measured_speed <= speed_q;
      current_height <= $signed(height_accumulator);
    end
  end

  `include "encoder_pi_speed_position_loop_unit_macros.svh"

  `EPSL_ASSERT_NOW(a_integ_bounded, 1'b1,
    (scaled_integral <= Q_ONE) && (scaled_integral >= Q_NEG_ONE), "integral out of range")
  `EPSL_ASSERT_NOW(a_pwm_in_period, out_valid, pwm_compare <= pwm_period,
    "pwm compare above period")
  `EPSL_ASSERT_NEXT(a_out_wait, (pc == STEP_OUT) && out_hold, pc == STEP_OUT,
    "sequencer left output step while result stalled")
  `EPSL_ASSERT_NOW(a_out_from_seq, $rose(out_valid), $past(pc) == STEP_OUT,
    "result raised outside output step")

endmodule
